FILE: design/heatmap_local_peak_finder_macros.svh
// ----------------------------------------------------------------------------
// Peak finder assertion macros
// Concurrent check wrappers shared by the peak finder modules.
// ----------------------------------------------------------------------------
`ifndef HEATMAP_LOCAL_PEAK_FINDER_MACROS_SVH
`define HEATMAP_LOCAL_PEAK_FINDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define HLPF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent
`define HLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: design/hlpf_pkg.sv
// ----------------------------------------------------------------------------
// Peak finder package
// Shared constants, types and the 3x3 window compare for the peak finder.
// ----------------------------------------------------------------------------
package hlpf_pkg;

   localparam int unsigned DEF_MAX_MAP_WIDTH  = 32;
   localparam int unsigned DEF_MAX_MAP_HEIGHT = 32;
   localparam int unsigned DEF_KEY_CHANNELS   = 17;

   localparam logic signed [15:0] DEF_THRESHOLD = 16'sd128;
   localparam int unsigned        DEF_MAP_SIZE  = 9;

   // results one item may cause, and depth of the result queue
   localparam int unsigned PEAKS_PER_ITEM     = 4;
   localparam int unsigned RESULT_QUEUE_DEPTH = 8;

   // register indexes
   localparam logic [1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd2;

   // one column of the window: current row and the two above
   typedef struct packed {
      logic signed [15:0] t2;
      logic signed [15:0] t1;
      logic signed [15:0] t0;
   } col_vec_type;

   typedef struct packed {
      logic [4:0]         col;
      logic [4:0]         row;
      logic [4:0]         ch;
      logic signed [15:0] score;
      logic               last;
   } peak_type;

   // map size 0 counts as 1, above the maximum counts as the maximum
   function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] maxv);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) r = 32'd1;
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   function automatic logic [4:0] lo5(logic [31:0] v);
      return v[4:0];
   endfunction

   // centre is a peak if at least thr and no enabled neighbour is greater
   function automatic logic is_peak(logic signed [15:0] centre,
                                    logic signed [15:0] thr,
                                    col_vec_type c0, col_vec_type c1,
                                    col_vec_type c2,
                                    logic [2:0] row_en, logic [2:0] col_en);
      logic signed [15:0] g [3][3];
      logic ok;
      g[0][0] = c0.t0; g[0][1] = c0.t1; g[0][2] = c0.t2;
      g[1][0] = c1.t0; g[1][1] = c1.t1; g[1][2] = c1.t2;
      g[2][0] = c2.t0; g[2][1] = c2.t1; g[2][2] = c2.t2;
      ok = (centre >= thr);
      for (int k = 0; k < 3; k++) begin
         for (int t = 0; t < 3; t++) begin
            if (col_en[k] && row_en[t]) begin
               if (g[k][t] > centre) ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

endpackage

FILE: design/heatmap_local_peak_finder.sv
// A peak leaves on rsp_ after the item closing its window passes the input stage,
// the window stage and the result queue. Throughput: one item per cycle while items
// give at most one peak each and rsp_tready is high; peaks leave one per cycle and
// req_tready drops while the result queue has fewer than four free places. The line
// memory has one read and one write port. Reset (synchronous) clears counters,
// pipeline and queue and reloads register defaults; the line memory is not cleared.
// ----------------------------------------------------------------------------
// Heatmap local peak finder
// 3x3 non-maximum suppression over a raster stream of per-channel scores.
// ----------------------------------------------------------------------------
`include "heatmap_local_peak_finder_macros.svh"

module heatmap_local_peak_finder #(
   parameter int unsigned MAX_MAP_WIDTH  = hlpf_pkg::DEF_MAX_MAP_WIDTH,
   parameter int unsigned MAX_MAP_HEIGHT = hlpf_pkg::DEF_MAX_MAP_HEIGHT,
   parameter int unsigned KEY_CHANNELS   = hlpf_pkg::DEF_KEY_CHANNELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] heatmap_score
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] col, [9:5] row, [14:10] channel,
                                    // [30:15] score, [31] zero
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import hlpf_pkg::*;

   localparam int unsigned CW   = $clog2(MAX_MAP_WIDTH);
   localparam int unsigned RW   = $clog2(MAX_MAP_HEIGHT);
   localparam int unsigned CHW  = (KEY_CHANNELS > 1) ? $clog2(KEY_CHANNELS) : 1;
   localparam int unsigned WW   = $clog2(MAX_MAP_WIDTH + 1);
   localparam int unsigned HW   = $clog2(MAX_MAP_HEIGHT + 1);
   localparam int unsigned MEMD = MAX_MAP_WIDTH * KEY_CHANNELS;
   localparam int unsigned AW   = $clog2(MEMD);
   localparam int unsigned DLD  = 2 * KEY_CHANNELS;

   // registers
   logic signed [15:0] thr_ff;
   logic [WW-1:0]      map_w_ff;
   logic [HW-1:0]      map_h_ff;

   // next position
   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [CHW-1:0] ch_ff;

   // input stage
   logic               s1_valid_ff;
   logic signed [15:0] s1_score_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [RW-1:0]      s1_row_ff;
   logic [CHW-1:0]     s1_ch_ff;
   logic [AW-1:0]      s1_addr;

   // window stage
   logic               s2_valid_ff;
   logic signed [15:0] s2_score_ff;
   logic [CW-1:0]      s2_col_ff;
   logic [RW-1:0]      s2_row_ff;
   logic [CHW-1:0]     s2_ch_ff;
   logic [AW-1:0]      s2_addr_ff;
   logic [31:0]        rd_ff;
   logic               fwd_ff;
   logic [31:0]        fwd_data_ff;
   logic [31:0]        line_word;
   logic [31:0]        wr_word;

   logic [31:0]  mem [MEMD];
   col_vec_type  dl_ff [DLD];

   logic           en;
   logic           accept;
   logic [CW-1:0]  pos_col;
   logic [RW-1:0]  pos_row;
   logic [CHW-1:0] pos_ch;

   col_vec_type c0, c1, c2;
   logic        r1, r2, k1, k2, c_last, r_last;
   logic [3:0]  cand_v;
   peak_type    cand [4];
   logic        later;

   assign csr_ready  = 1'b1;
   assign req_tready = en;
   assign accept     = req_tvalid & en;

   // register writes, sizes stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= DEF_THRESHOLD;
         map_w_ff <= WW'(clamp_size(32'(DEF_MAP_SIZE), 32'(MAX_MAP_WIDTH)));
         map_h_ff <= HW'(clamp_size(32'(DEF_MAP_SIZE), 32'(MAX_MAP_HEIGHT)));
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD:  thr_ff <= csr_data;
            CSR_MAP_WIDTH:  map_w_ff <= WW'(clamp_size(32'(csr_data[5:0]),
                                                     32'(MAX_MAP_WIDTH)));
            CSR_MAP_HEIGHT: map_h_ff <= HW'(clamp_size(32'(csr_data[5:0]),
                                                     32'(MAX_MAP_HEIGHT)));
            default: ;
         endcase
      end
   end

   // position of the incoming item, folded into the map
   always_comb begin
      pos_ch  = req_tuser ? '0 : ch_ff;
      pos_col = (req_tuser || (WW'(col_ff) >= map_w_ff)) ? '0 : col_ff;
      pos_row = (req_tuser || (HW'(row_ff) >= map_h_ff)) ? '0 : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ch_ff  <= '0;
      end else if (accept) begin
         if (32'(pos_ch) == KEY_CHANNELS - 1) begin
            ch_ff <= '0;
            if (WW'(pos_col) == map_w_ff - WW'(1)) begin
               col_ff <= '0;
               row_ff <= (HW'(pos_row) == map_h_ff - HW'(1)) ? '0 : pos_row + RW'(1);
            end else begin
               col_ff <= pos_col + CW'(1);
               row_ff <= pos_row;
            end
         end else begin
            ch_ff  <= pos_ch + CHW'(1);
            col_ff <= pos_col;
            row_ff <= pos_row;
         end
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         fwd_ff      <= s1_valid_ff && s2_valid_ff && (s1_addr == s2_addr_ff);
      end
   end

   assign s1_addr = AW'(AW'(s1_col_ff) * AW'(KEY_CHANNELS) + AW'(s1_ch_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         s1_score_ff <= req_tdata;
         s1_col_ff   <= pos_col;
         s1_row_ff   <= pos_row;
         s1_ch_ff    <= pos_ch;
         s2_score_ff <= s1_score_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_ch_ff    <= s1_ch_ff;
         s2_addr_ff  <= s1_addr;
         fwd_data_ff <= wr_word;
      end
   end

   // line memory: per column and channel, the two rows above
   assign line_word = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_word   = {line_word[15:0], s2_score_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         if (s2_valid_ff) mem[s2_addr_ff] <= wr_word;
         rd_ff <= mem[s1_addr];
      end
   end

   // column delay line: taps one and two columns back on the same channel
   always_ff @(posedge clock) begin
      if (en && s2_valid_ff) begin
         dl_ff[0] <= c0;
         for (int i = 1; i < DLD; i++) dl_ff[i] <= dl_ff[i - 1];
      end
   end

   // window and the four candidate centres
   always_comb begin
      c0     = '{t2: line_word[31:16], t1: line_word[15:0], t0: s2_score_ff};
      c1     = dl_ff[KEY_CHANNELS - 1];
      c2     = dl_ff[DLD - 1];
      r1     = (32'(s2_row_ff) >= 1);
      r2     = (32'(s2_row_ff) >= 2);
      k1     = (32'(s2_col_ff) >= 1);
      k2     = (32'(s2_col_ff) >= 2);
      c_last = (WW'(s2_col_ff) == map_w_ff - WW'(1));
      r_last = (HW'(s2_row_ff) == map_h_ff - HW'(1));

      cand_v[0] = r1 && k1 &&
                  is_peak(c1.t1, thr_ff, c0, c1, c2, {r2, 2'b11}, {k2, 2'b11});
      cand_v[1] = r1 && c_last &&
                  is_peak(c0.t1, thr_ff, c0, c1, c2, {r2, 2'b11}, {1'b0, k1, 1'b1});
      cand_v[2] = r_last && k1 &&
                  is_peak(c1.t0, thr_ff, c0, c1, c2, {1'b0, r1, 1'b1}, {k2, 2'b11});
      cand_v[3] = r_last && c_last &&
                  is_peak(c0.t0, thr_ff, c0, c1, c2, {1'b0, r1, 1'b1},
                          {1'b0, k1, 1'b1});

      cand[0] = '{col: lo5(32'(s2_col_ff) - 32'd1), row: lo5(32'(s2_row_ff) - 32'd1),
                  ch: lo5(32'(s2_ch_ff)), score: c1.t1, last: 1'b0};
      cand[1] = '{col: lo5(32'(s2_col_ff)), row: lo5(32'(s2_row_ff) - 32'd1),
                  ch: lo5(32'(s2_ch_ff)), score: c0.t1, last: 1'b0};
      cand[2] = '{col: lo5(32'(s2_col_ff) - 32'd1), row: lo5(32'(s2_row_ff)),
                  ch: lo5(32'(s2_ch_ff)), score: c1.t0, last: 1'b0};
      cand[3] = '{col: lo5(32'(s2_col_ff)), row: lo5(32'(s2_row_ff)),
                  ch: lo5(32'(s2_ch_ff)), score: c0.t0, last: 1'b0};

      // mark the final peak of this item
      later = 1'b0;
      for (int k = 3; k >= 0; k--) begin
         cand[k].last = cand_v[k] && !later;
         later        = later | cand_v[k];
      end

      cand_v = cand_v & {4{s2_valid_ff & en}};
   end

   peak_type out_peak;

   hlpf_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cand_v),
      .push_data  (cand),
      .room       (en),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_peak)
   );

   assign rsp_tdata = {1'b0, out_peak.score, out_peak.ch, out_peak.row, out_peak.col};
   assign rsp_tlast = out_peak.last;

   `HLPF_ASSERT_NOW(a_ch_range, clock, reset, 1'b1, 32'(ch_ff) < KEY_CHANNELS)
   `HLPF_ASSERT_NEXT(a_accept_s1, clock, reset, accept, s1_valid_ff)
   `HLPF_ASSERT_NEXT(a_stall_hold, clock, reset, s2_valid_ff && !en,
                     s2_valid_ff && $stable(s2_addr_ff))

endmodule

FILE: design/hlpf_result_queue.sv
// ----------------------------------------------------------------------------
// Peak result queue
// Takes up to four peaks per cycle in order and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "heatmap_local_peak_finder_macros.svh"

module hlpf_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           push_valid,
   input  hlpf_pkg::peak_type   push_data [4],
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hlpf_pkg::peak_type   out_data
);
   import hlpf_pkg::*;

   localparam int unsigned QD  = RESULT_QUEUE_DEPTH;
   localparam int unsigned QCW = $clog2(QD + 1);

   peak_type       q_ff [QD];
   peak_type       q_in [QD];
   logic [QCW-1:0] cnt_ff;
   logic [QCW-1:0] cnt_in;
   logic [QCW-1:0] slot;
   logic           pop;
   logic [2:0]     push_n;

   assign pop       = out_valid & out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_data  = q_ff[0];
   assign room      = (cnt_ff <= QCW'(QD - PEAKS_PER_ITEM));

   // shift out head, then append the new peaks behind the survivors
   always_comb begin
      for (int j = 0; j < QD; j++) q_in[j] = q_ff[j];
      if (pop) begin
         for (int j = 0; j < QD - 1; j++) q_in[j] = q_ff[j + 1];
      end
      slot   = cnt_ff - QCW'(pop);
      push_n = '0;
      for (int k = 0; k < 4; k++) begin
         if (push_valid[k]) begin
            for (int j = 0; j < QD; j++) begin
               if (QCW'(j) == slot) q_in[j] = push_data[k];
            end
            slot   = slot + QCW'(1);
            push_n = push_n + 3'd1;
         end
      end
      cnt_in = slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QD; j++) q_ff[j] <= q_in[j];
   end

   `HLPF_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, 32'(cnt_ff) <= QD)
   `HLPF_ASSERT_NOW(a_push_room, clock, reset, push_n != 3'd0,
                    32'(cnt_ff) <= QD - PEAKS_PER_ITEM)
   `HLPF_ASSERT_NEXT(a_pop_only, clock, reset, pop && (push_n == 3'd0),
                     cnt_ff == $past(cnt_ff) - QCW'(1))

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Peak finder testbench
// Streams heatmap scores through the 3x3 peak finder under bursty input and
// a stalling output, predicts every peak with an internal line store, and
// compares each result field by field across several map settings.
// ----------------------------------------------------------------------------
module tb_top;
   import hlpf_pkg::*;

   typedef struct {
      logic signed [15:0] score;
      logic               frame_start;
   } score_item_type;

   typedef struct {
      logic [4:0]         col;
      logic [4:0]         row;
      logic [4:0]         ch;
      logic signed [15:0] score;
      logic               last;
   } peak_rec_type;

   localparam int MAXW = 32;
   localparam int MAXH = 32;
   localparam int NCH  = 17;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_THRESHOLD;
   logic [15:0] csr_data = '0;

   heatmap_local_peak_finder uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] line_mem [3][MAXW][NCH];
   int                 pos_col, pos_row, pos_ch;
   logic signed [15:0] cfg_thr = DEF_THRESHOLD;
   logic [5:0]         cfg_width = 6'd9;
   logic [5:0]         cfg_height = 6'd9;

   score_item_type pending_scores [$];
   peak_rec_type   expected_peaks [$];
   peak_rec_type   new_peaks [$];
   int             n_accepted = 0;
   bit             failed = 1'b0;

   function automatic int clip_size(logic [5:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // judge one centre against its clipped 3x3 window
   task automatic judge_centre(int cy, int cx, int k, int w, int h);
      logic signed [15:0] v;
      int                 y0, y1, x0, x1;
      bit                 ok;
      peak_rec_type       p;
      v  = line_mem[cy % 3][cx][k];
      y0 = (cy > 0) ? cy - 1 : cy;
      y1 = (cy + 1 < h) ? cy + 1 : cy;
      x0 = (cx > 0) ? cx - 1 : cx;
      x1 = (cx + 1 < w) ? cx + 1 : cx;
      ok = (v >= cfg_thr);
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            if (line_mem[y % 3][x][k] > v) ok = 1'b0;
      if (ok) begin
         p.col = cx[4:0]; p.row = cy[4:0]; p.ch = k[4:0];
         p.score = v; p.last = 1'b0;
         new_peaks.push_back(p);
      end
   endtask

   // store one score and queue the peaks it closes
   task automatic predict_peaks(logic signed [15:0] s, logic fs);
      int w, h, r, c, k;
      w = clip_size(cfg_width, MAXW);
      h = clip_size(cfg_height, MAXH);
      if (fs) begin
         pos_col = 0; pos_row = 0; pos_ch = 0;
      end
      if (pos_col >= w) pos_col = 0;
      if (pos_row >= h) pos_row = 0;
      if (pos_ch >= NCH) pos_ch = 0;
      r = pos_row; c = pos_col; k = pos_ch;
      line_mem[r % 3][c][k] = s;
      new_peaks.delete();
      if (r >= 1) begin
         if (c >= 1) judge_centre(r - 1, c - 1, k, w, h);
         if (c == w - 1) judge_centre(r - 1, c, k, w, h);
      end
      if (r == h - 1) begin
         if (c >= 1) judge_centre(r, c - 1, k, w, h);
         if (c == w - 1) judge_centre(r, c, k, w, h);
      end
      if (new_peaks.size() > 0) new_peaks[new_peaks.size() - 1].last = 1'b1;
      foreach (new_peaks[i]) expected_peaks.push_back(new_peaks[i]);
      pos_ch = k + 1;
      if (pos_ch >= NCH) begin
         pos_ch  = 0;
         pos_col = c + 1;
         if (pos_col >= w) begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= h) pos_row = 0;
         end
      end
   endtask

   // score driver: bursts with random gaps
   int             gap_left = 0;
   int             burst_left = 1;
   bit             offer;
   score_item_type next_item;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_peaks(req_tdata, req_tuser);
            n_accepted++;
         end
         offer = req_tvalid && !req_tready;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_scores.size() > 0) begin
               next_item = pending_scores[0];
               pending_scores.delete(0);
               offer = 1'b1;
               req_tdata <= next_item.score;
               req_tuser <= next_item.frame_start;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // result receiver: random stall pattern plus one long hold-off
   int  hold_left = 0;
   bit  held_once = 1'b0;
   int  stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase++;
         if (!held_once && n_accepted >= 60) begin
            held_once = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_phase[6]) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // result checker
   peak_rec_type want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_peaks.size() == 0) begin
            $display("%0t: unexpected peak tdata=%h tlast=%b", $time, rsp_tdata, rsp_tlast);
            failed = 1'b1;
         end else begin
            want = expected_peaks[0];
            expected_peaks.delete(0);
            if (rsp_tdata !== {1'b0, want.score, want.ch, want.row, want.col}
                || rsp_tlast !== want.last) begin
               $display("%0t: peak mismatch expected col=%0d row=%0d ch=%0d score=%h last=%b",
                        $time, want.col, want.row, want.ch, want.score, want.last);
               $display("%0t:   actual col=%0d row=%0d ch=%0d score=%h last=%b pad=%b",
                        $time, rsp_tdata[4:0], rsp_tdata[9:5], rsp_tdata[14:10],
                        rsp_tdata[30:15], rsp_tlast, rsp_tdata[31]);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD:  cfg_thr = val;
         CSR_MAP_WIDTH:  cfg_width = val[5:0];
         CSR_MAP_HEIGHT: cfg_height = val[5:0];
         default: ;
      endcase
   endtask

   // wait until every item is taken and every peak has left
   task automatic drain();
      while (pending_scores.size() > 0 || req_tvalid || expected_peaks.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_score();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 6) * 64 - 128);
   endfunction

   task automatic add_score(logic [15:0] s, logic fs);
      score_item_type it;
      it.score = s;
      it.frame_start = fs;
      pending_scores.push_back(it);
   endtask

   // new settings, then a frame that starts cleanly
   task automatic run_phase(logic [15:0] thr, logic [15:0] w, logic [15:0] h, int n);
      drain();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_MAP_WIDTH, w);
      write_csr(CSR_MAP_HEIGHT, h);
      for (int i = 0; i < n; i++)
         add_score(rand_score(), i == 0 || $urandom_range(0, 149) == 0);
   endtask

   initial begin
      logic [15:0] edge_scores [20];
      pos_col = 0; pos_row = 0; pos_ch = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: 1x1 map, each score judged alone against the default threshold
      edge_scores = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0080,
                      16'h007F, 16'h5555, 16'hAAAA, 16'h0081, 16'hFF80, 16'h0100,
                      16'h7FFE, 16'h8001, 16'h00FF, 16'h0080, 16'h4000, 16'h0200,
                      16'h0300, 16'hC000};
      write_csr(CSR_MAP_WIDTH, 16'd1);
      write_csr(CSR_MAP_HEIGHT, 16'd1);
      foreach (edge_scores[i]) add_score(edge_scores[i], i == 0 || i == 18);

      // random phases, extremes of every register among them
      run_phase(16'd128, 16'd0, 16'd0, 30);
      run_phase(16'h8000, 16'd2, 16'd2, 60);
      run_phase(16'd0, 16'd3, 16'd3, 90);
      run_phase(16'h7FFF, 16'd1, 16'd3, 51);
      run_phase(16'hFF38, 16'd63, 16'd1, 40);
      run_phase(16'($urandom), 16'd4, 16'd2, 50);
      run_phase(16'd0, 16'd1, 16'd63, 40);
      run_phase(16'hFF9C, 16'd32, 16'd32, 30);
      run_phase(16'd64, 16'd2, 16'd3, 50);

      drain();
      if (!failed && expected_peaks.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/hlpf_pkg.sv
design/hlpf_result_queue.sv
design/heatmap_local_peak_finder.sv
sim/tb_top.sv
